// ===== rtl/core/cie_pkg.sv =====
// Package for the compressed instruction executor: codes and widths.
// No dependencies.
package cie_pkg;
   localparam int XLEN = 64;
   localparam int REG_BITS = 5;
   localparam logic [1:0] MEM_NONE = 2'd0;
   localparam logic [1:0] MEM_READ = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;
   localparam logic [1:0] TRAP_NONE = 2'd0;
   localparam logic [1:0] TRAP_BREAK = 2'd1;
   localparam logic [1:0] TRAP_ILLEGAL = 2'd2;
   localparam logic OP_EXEC = 1'b0;
   localparam logic OP_LOAD_RET = 1'b1;
endpackage

// ===== rtl/core/compressed_instruction_executor_unit.sv =====
// Top level of the compressed instruction executor: register file, decode, execute.
// Depends on cie_pkg.
//
// Usage: req_ carries one item per transfer, either an instruction to execute
// (req_opcode 0) or the data for the pending load (req_opcode 1). rsp_ carries
// one result per item: next PC, branch flag, memory request, trap cause.
// Stage 1 reads the two-read-port register file (a registered memory read);
// stage 2 executes, writes back and loads the output register. One item per
// cycle is taken while req_stall is low. Writes in stage 2 are forwarded to
// the item in stage 1, so a dependent instruction may follow the next cycle.
// Reset clears the pipeline valid bits, load state and rv32_ff; the register
// file is cleared by a pass after reset, one entry a cycle, during which
// req_stall stays high. When rsp_stall is high while a result is valid, the
// result holds and the pipeline holds behind it; req_stall follows rsp_stall
// whenever a result is waiting.
module compressed_instruction_executor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_instruction,
   input  logic [63:0] req_fetch_pc,
   input  logic [63:0] req_load_data,
   input  logic        req_load_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_next_pc,
   output logic        rsp_branch_taken,
   output logic [1:0]  rsp_mem_request,
   output logic [63:0] rsp_mem_address,
   output logic        rsp_mem_size,
   output logic [63:0] rsp_store_data,
   output logic [1:0]  rsp_trap_cause
);
   typedef struct packed {
      logic        opcode;
      logic [15:0] inst;
      logic [63:0] pc;
      logic [63:0] ldata;
      logic        lok;
      logic [4:0]  ra;
      logic [4:0]  rb;
   } item_type;

   logic [63:0] regs [32];
   logic        rv32_ff;
   logic        clr_ff;
   logic [4:0]  clr_idx_ff;
   logic        s1_valid_ff, s2v_ff;
   item_type    s1_ff, req_item;
   logic [63:0] rda_ff, rdb_ff;
   logic [4:0]  pdst_ff;
   logic        pword_ff, pout_ff;
   logic        advance, take;
   logic        wen;
   logic [4:0]  wdst;
   logic [63:0] wval;
   logic        wb_en_ff;
   logic [4:0]  wb_dst_ff;
   logic [63:0] wb_val_ff;

   // Register address choice per encoding.
   always_comb begin
      logic [15:0] i;
      i = req_instruction;
      req_item.opcode = req_opcode;
      req_item.inst = i;
      req_item.pc = req_fetch_pc;
      req_item.ldata = req_load_data;
      req_item.lok = req_load_ok;
      req_item.ra = i[11:7];
      req_item.rb = i[6:2];
      if (i[1:0] == 2'd0) begin
         req_item.ra = (i[15:13] == 3'd0) ? 5'd2 : {2'b01, i[9:7]};
         req_item.rb = {2'b01, i[4:2]};
      end else if (i[1:0] == 2'd1 && i[15:13] >= 3'd4) begin
         req_item.ra = {2'b01, i[9:7]};
         req_item.rb = {2'b01, i[4:2]};
      end else if (i[1:0] == 2'd1 && i[15:13] == 3'd3 && i[11:7] == 5'd2) begin
         req_item.ra = 5'd2;
      end else if (i[1:0] == 2'd2 && (i[15:13] == 3'd2 || i[15:13] == 3'd3
                                      || i[15:13] >= 3'd6)) begin
         req_item.ra = 5'd2;
      end
   end

   assign advance = !s2v_ff || !rsp_stall;
   assign req_stall = clr_ff || !advance;
   assign take = req_valid && !req_stall;

   // Write port: clearing pass or stage-2 writeback. Read data registered.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         regs[clr_idx_ff] <= '0;
      end else if (wen && advance) begin
         regs[wdst] <= wval;
      end
      if (take) begin
         rda_ff <= regs[req_item.ra];
         rdb_ff <= regs[req_item.rb];
      end
   end

   // Writeback of the cycle that loaded stage 1, for the forwarding path.
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_en_ff <= 1'b0;
      end else if (advance) begin
         wb_en_ff <= take && wen && s1_valid_ff;
      end
      if (advance) begin
         wb_dst_ff <= wdst;
         wb_val_ff <= wval;
      end
   end

   logic [63:0] a, b;
   always_comb begin
      a = rda_ff;
      b = rdb_ff;
      if (wb_en_ff && wb_dst_ff == s1_ff.ra) a = wb_val_ff;
      if (wb_en_ff && wb_dst_ff == s1_ff.rb) b = wb_val_ff;
      if (s1_ff.ra == 5'd0) a = '0;
      if (s1_ff.rb == 5'd0) b = '0;
   end

   logic [63:0] npc, addr, sdata;
   logic        taken, size, ld, lword, ill;
   logic [1:0]  req, trap;
   logic [4:0]  ldst;
   always_comb begin
      logic [15:0] i;
      logic [2:0]  f3;
      logic [4:0]  r, r2, rp1, rp2;
      logic [5:0]  shamt;
      logic [63:0] imm6, joff, boff, pc2, jt;
      i = s1_ff.inst;
      f3 = i[15:13];
      r = i[11:7];
      r2 = i[6:2];
      rp1 = {2'b01, i[9:7]};
      rp2 = {2'b01, i[4:2]};
      shamt = {i[12], i[6:2]};
      imm6 = {{58{i[12]}}, shamt};
      joff = {{53{i[12]}}, i[8], i[10:9], i[6], i[7], i[2], i[11], i[5:3], 1'b0};
      boff = {{56{i[12]}}, i[6:5], i[2], i[11:10], i[4:3], 1'b0};
      pc2 = s1_ff.pc + 64'd2;
      jt = {a[63:1], 1'b0};
      npc = pc2; addr = '0; sdata = '0; taken = 1'b0; size = 1'b0;
      req = cie_pkg::MEM_NONE; trap = cie_pkg::TRAP_NONE;
      ld = 1'b0; lword = 1'b0; ldst = rp2; ill = 1'b0;
      wen = 1'b0; wdst = r; wval = '0;
      unique case (i[1:0])
         2'd0: begin
            unique case (f3)
               3'd0: begin
                  if (i[12:5] == 8'd0) ill = 1'b1;
                  else begin
                     wen = 1'b1; wdst = rp2;
                     wval = a + {54'd0, i[10:7], i[12:11], i[5], i[6], 2'b00};
                  end
               end
               3'd2: begin
                  ld = 1'b1; lword = 1'b1; req = cie_pkg::MEM_READ;
                  addr = a + {57'd0, i[5], i[12:10], i[6], 2'b00};
               end
               3'd3: begin
                  if (rv32_ff) ill = 1'b1;
                  else begin
                     ld = 1'b1; req = cie_pkg::MEM_READ; size = 1'b1;
                     addr = a + {56'd0, i[6:5], i[12:10], 3'b000};
                  end
               end
               3'd6: begin
                  req = cie_pkg::MEM_WRITE; sdata = b;
                  addr = a + {57'd0, i[5], i[12:10], i[6], 2'b00};
               end
               3'd7: begin
                  if (rv32_ff) ill = 1'b1;
                  else begin
                     req = cie_pkg::MEM_WRITE; size = 1'b1; sdata = b;
                     addr = a + {56'd0, i[6:5], i[12:10], 3'b000};
                  end
               end
               default: ill = 1'b1;
            endcase
         end
         2'd1: begin
            unique case (f3)
               3'd0: begin wen = 1'b1; wval = a + imm6; end
               3'd1: begin
                  if (rv32_ff) begin
                     wen = 1'b1; wdst = 5'd1; wval = pc2;
                     npc = s1_ff.pc + joff; taken = 1'b1;
                  end else if (r == 5'd0) ill = 1'b1;
                  else begin
                     wen = 1'b1;
                     wval = a + imm6;
                     wval = {{32{wval[31]}}, wval[31:0]};
                  end
               end
               3'd2: begin wen = 1'b1; wval = imm6; end
               3'd3: begin
                  if (r == 5'd2) begin
                     if ({i[12], i[4:3], i[5], i[2], i[6]} == 6'd0) ill = 1'b1;
                     else begin
                        wen = 1'b1;
                        wval = a + {{55{i[12]}}, i[4:3], i[5], i[2], i[6], 4'd0};
                     end
                  end else if (shamt == 6'd0) ill = 1'b1;
                  else begin wen = 1'b1; wval = {imm6[51:0], 12'd0}; end
               end
               3'd4: begin
                  wdst = rp1;
                  if (i[11] == 1'b0) begin
                     if (rv32_ff && shamt[5]) ill = 1'b1;
                     else begin
                        wen = 1'b1;
                        wval = i[10] ? 64'($signed(a) >>> shamt) : a >> shamt;
                     end
                  end else if (i[10] == 1'b0) begin
                     wen = 1'b1; wval = a & imm6;
                  end else if (!i[12]) begin
                     wen = 1'b1;
                     unique case (i[6:5])
                        2'd0: wval = a - b;
                        2'd1: wval = a ^ b;
                        2'd2: wval = a | b;
                        default: wval = a & b;
                     endcase
                  end else if (!i[6] && !rv32_ff) begin
                     wen = 1'b1;
                     wval = i[5] ? a + b : a - b;
                     wval = {{32{wval[31]}}, wval[31:0]};
                  end else ill = 1'b1;
               end
               3'd5: begin npc = s1_ff.pc + joff; taken = 1'b1; end
               default: begin
                  if ((a == 64'd0) == (f3 == 3'd6)) begin
                     npc = s1_ff.pc + boff; taken = 1'b1;
                  end
               end
            endcase
         end
         2'd2: begin
            unique case (f3)
               3'd0: begin
                  if (rv32_ff && shamt[5]) ill = 1'b1;
                  else begin wen = 1'b1; wval = a << shamt; end
               end
               3'd2: begin
                  if (r == 5'd0) ill = 1'b1;
                  else begin
                     ld = 1'b1; lword = 1'b1; ldst = r; req = cie_pkg::MEM_READ;
                     addr = a + {56'd0, i[3:2], i[12], i[6:4], 2'b00};
                  end
               end
               3'd3: begin
                  if (rv32_ff || r == 5'd0) ill = 1'b1;
                  else begin
                     ld = 1'b1; ldst = r; req = cie_pkg::MEM_READ; size = 1'b1;
                     addr = a + {55'd0, i[4:2], i[12], i[6:5], 3'b000};
                  end
               end
               3'd4: begin
                  if (!i[12]) begin
                     if (r2 != 5'd0) begin wen = 1'b1; wval = b; end
                     else if (r == 5'd0) ill = 1'b1;
                     else begin npc = jt; taken = 1'b1; end
                  end else if (r == 5'd0 && r2 == 5'd0) begin
                     trap = cie_pkg::TRAP_BREAK;
                  end else if (r2 == 5'd0) begin
                     npc = jt; taken = 1'b1; wen = 1'b1; wdst = 5'd1; wval = pc2;
                  end else begin
                     wen = 1'b1; wval = a + b;
                  end
               end
               3'd6: begin
                  req = cie_pkg::MEM_WRITE; sdata = b;
                  addr = a + {56'd0, i[8:7], i[12:9], 2'b00};
               end
               3'd7: begin
                  if (rv32_ff) ill = 1'b1;
                  else begin
                     req = cie_pkg::MEM_WRITE; size = 1'b1; sdata = b;
                     addr = a + {55'd0, i[9:7], i[12:10], 3'b000};
                  end
               end
               default: ill = 1'b1;
            endcase
         end
         default: ill = 1'b1;
      endcase
      if (ill) trap = cie_pkg::TRAP_ILLEGAL;
      if (trap != cie_pkg::TRAP_NONE) begin
         npc = s1_ff.pc; taken = 1'b0; req = cie_pkg::MEM_NONE;
         addr = '0; size = 1'b0; sdata = '0; wen = 1'b0; ld = 1'b0;
      end
      if (s1_ff.opcode == cie_pkg::OP_LOAD_RET) begin
         npc = '0; taken = 1'b0; req = cie_pkg::MEM_NONE; addr = '0; size = 1'b0;
         sdata = '0; trap = cie_pkg::TRAP_NONE; ld = 1'b0;
         wen = pout_ff && s1_ff.lok;
         wdst = pdst_ff;
         wval = pword_ff ? {{32{s1_ff.ldata[31]}}, s1_ff.ldata[31:0]} : s1_ff.ldata;
      end
      if (!s1_valid_ff || wdst == 5'd0) wen = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv32_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2v_ff <= 1'b0;
         pout_ff <= 1'b0;
         pdst_ff <= '0;
         pword_ff <= 1'b0;
      end else begin
         if (csr_write_enable) rv32_ff <= csr_write_data;
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + 5'd1;
            if (clr_idx_ff == 5'd31) clr_ff <= 1'b0;
         end
         if (advance) begin
            s1_valid_ff <= take;
            s2v_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               if (s1_ff.opcode == cie_pkg::OP_LOAD_RET) pout_ff <= 1'b0;
               else if (ld) begin
                  pout_ff <= 1'b1; pdst_ff <= ldst; pword_ff <= lword;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) s1_ff <= req_item;
      if (advance) begin
         rsp_next_pc <= npc;
         rsp_branch_taken <= taken;
         rsp_mem_request <= req;
         rsp_mem_address <= addr;
         rsp_mem_size <= size;
         rsp_store_data <= sdata;
         rsp_trap_cause <= trap;
      end
   end

   assign rsp_valid = s2v_ff;

`ifndef SYNTHESIS
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !take) else $error("transfer during register clear");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_next_pc))
      else $error("result lost under stall");
   a_trap_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trap_cause != cie_pkg::TRAP_NONE)
      |-> rsp_mem_request == cie_pkg::MEM_NONE && !rsp_branch_taken)
      else $error("trap with side effect");
   a_s2_from_s1: assert property (@(posedge clock) disable iff (reset)
      ($rose(s2v_ff)) |-> $past(s1_valid_ff)) else $error("result without item");
`endif
endmodule
